/* hw/rtl/mtfl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package mtfl_pkg;

   localparam int KEY_W = 32;
   localparam int POS_W = 5;
   localparam int LEN_W = 5;

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_SEARCH = 2'd1;
   localparam logic [1:0] FUNC_MTF    = 2'd2;
   localparam logic [1:0] FUNC_DELETE = 2'd3;

   typedef struct packed {
      logic [1:0]              func;
      logic signed [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] position;
      logic [LEN_W-1:0] length;
      logic             full_error;
   } rsp_type;

   // Control broadcast from the sequencer to every cell.
   typedef struct packed {
      logic cmp_en;     // capture the compare result
      logic ins_all;    // every cell takes its front neighbor
      logic mtf;        // cells up to the first match take their front neighbor
      logic del;        // cells from the first match on take their back neighbor
   } cell_ctrl_type;

endpackage
`default_nettype wire

/* hw/rtl/mtfl_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module mtfl_cell #(
   parameter int IDX      = 0,
   parameter int KEY_BITS = 32,
   parameter int CNT_BITS = 5
) (
   input  wire                         clock,
   input  wire mtfl_pkg::cell_ctrl_type ctrl,
   input  wire logic [KEY_BITS-1:0]    key,
   input  wire logic [CNT_BITS-1:0]    count,
   input  wire logic [KEY_BITS-1:0]    front_entry,
   input  wire logic [KEY_BITS-1:0]    back_entry,
   input  wire logic                   hit_in,
   input  wire logic [CNT_BITS-1:0]    pos_in,
   output logic      [KEY_BITS-1:0]    entry,
   output logic                        hit_out,
   output logic      [CNT_BITS-1:0]    pos_out
);

   logic [KEY_BITS-1:0] entry_ff, entry_in;
   logic                match_ff, match_in;

   always_comb begin
      match_in = match_ff;
      if (ctrl.cmp_en) begin
         match_in = (entry_ff == key) && (count > CNT_BITS'(IDX));
      end
      entry_in = entry_ff;
      // hit_in means an earlier cell already matched.
      if (ctrl.ins_all || (ctrl.mtf && !hit_in)) begin
         entry_in = front_entry;
      end else if (ctrl.del && (hit_in || match_ff)) begin
         entry_in = back_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign entry   = entry_ff;
   assign hit_out = hit_in || match_ff;
   assign pos_out = hit_in ? pos_in : (match_ff ? CNT_BITS'(IDX + 1) : '0);

endmodule
`default_nettype wire

/* hw/rtl/move_to_front_list_search.sv */
`timescale 1ns / 1ps
`default_nettype none
// An accepted item goes through a compare step and an update step before its result is in the output register.
// Items are taken one at a time; a compare cycle in the cell row is
// followed by an update cycle in which the row shifts and the next item may enter.
// An update waits while the previous result is still stalled at the output.
// Reset clears the key count, the sequencer and the output valid; keys are not cleared.
module move_to_front_list_search #(
   parameter int DEPTH    = 16,
   parameter int KEY_BITS = 32
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire mtfl_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output mtfl_pkg::rsp_type      rsp_data
);

   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam int KEY_EXT  = (KEY_BITS > mtfl_pkg::KEY_W) ? KEY_BITS : mtfl_pkg::KEY_W;

   typedef enum logic [1:0] {S_IDLE, S_CMP, S_UPD} state_type;

   state_type               state_ff, state_in;
   logic [1:0]              func_ff, func_in;
   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   mtfl_pkg::rsp_type       rsp_data_ff, rsp_data_in;

   logic [KEY_EXT-1:0]      key_ext;
   logic                    req_accept, commit, full, any_hit;
   logic                    do_insert, do_mtf, do_del;
   mtfl_pkg::cell_ctrl_type ctrl;

   logic [KEY_BITS-1:0]     entry_w [DEPTH];
   logic [DEPTH:0]          hit_c;
   logic [CNT_BITS-1:0]     pos_c [DEPTH+1];

   assign key_ext    = KEY_EXT'(req_data.key);
   assign full       = (count_ff == CNT_BITS'(DEPTH));
   assign any_hit    = hit_c[DEPTH];
   assign commit     = (state_ff == S_UPD) && !(rsp_valid_ff && rsp_stall);
   assign req_stall  = (state_ff == S_CMP) || ((state_ff == S_UPD) && !commit);
   assign req_accept = req_valid && !req_stall;

   assign do_insert = (func_ff == mtfl_pkg::FUNC_INSERT) && !full;
   assign do_mtf    = (func_ff == mtfl_pkg::FUNC_MTF) && any_hit;
   assign do_del    = (func_ff == mtfl_pkg::FUNC_DELETE) && any_hit;

   assign ctrl.cmp_en  = (state_ff == S_CMP);
   assign ctrl.ins_all = commit && do_insert;
   assign ctrl.mtf     = commit && do_mtf;
   assign ctrl.del     = commit && do_del;

   assign hit_c[0] = 1'b0;
   assign pos_c[0] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [KEY_BITS-1:0] front_w, back_w;
      if (i == 0) begin : g_front
         assign front_w = key_ff;
      end else begin : g_mid
         assign front_w = entry_w[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign back_w = entry_w[i];
      end else begin : g_inner
         assign back_w = entry_w[i+1];
      end
      mtfl_cell #(
         .IDX      (i),
         .KEY_BITS (KEY_BITS),
         .CNT_BITS (CNT_BITS)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .key         (key_ff),
         .count       (count_ff),
         .front_entry (front_w),
         .back_entry  (back_w),
         .hit_in      (hit_c[i]),
         .pos_in      (pos_c[i]),
         .entry       (entry_w[i]),
         .hit_out     (hit_c[i+1]),
         .pos_out     (pos_c[i+1])
      );
   end

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            state_in = S_UPD;
         end
         S_UPD: begin
            if (commit) begin
               state_in = req_accept ? S_CMP : S_IDLE;
               if (do_insert) begin
                  count_in = count_ff + CNT_BITS'(1);
               end else if (do_del) begin
                  count_in = count_ff - CNT_BITS'(1);
               end
               rsp_valid_in = 1'b1;
               if (func_ff == mtfl_pkg::FUNC_INSERT) begin
                  rsp_data_in.found    = !full;
                  rsp_data_in.position = full ? '0 : mtfl_pkg::POS_W'(1);
               end else begin
                  rsp_data_in.found    = any_hit;
                  rsp_data_in.position = mtfl_pkg::POS_W'(pos_c[DEPTH]);
               end
               rsp_data_in.length     = mtfl_pkg::LEN_W'(count_in);
               rsp_data_in.full_error = (func_ff == mtfl_pkg::FUNC_INSERT) && full;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (req_accept) begin
         func_in = req_data.func;
         key_in  = key_ext[KEY_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff     <= func_in;
      key_ff      <= key_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

/* sim/tb_move_to_front_list_search.sv */
`timescale 1ns / 1ps

// Tracks the list contents as the block should hold them and the result items still owed.
class list_order_tracker #(int SLOTS = 16);
   logic [mtfl_pkg::KEY_W-1:0] keys_held[SLOTS];
   int                         n_held;
   mtfl_pkg::rsp_type          pending_rsp[$];
   int                         n_errors;
   int                         n_checked;
   int                         n_hits;
   int                         n_refused;

   function new();
      n_held    = 0;
      n_errors  = 0;
      n_checked = 0;
      n_hits    = 0;
      n_refused = 0;
   endfunction

   // Applies one accepted input item to the tracked list and queues the result item it must give.
   function void note_request(mtfl_pkg::req_type item);
      mtfl_pkg::rsp_type exp_rsp;
      int                idx;
      int                j;
      exp_rsp = '0;
      if (item.func == mtfl_pkg::FUNC_INSERT) begin
         if (n_held >= SLOTS) begin
            exp_rsp.full_error = 1'b1;
            n_refused++;
         end else begin
            for (j = n_held; j > 0; j--) keys_held[j] = keys_held[j-1];
            keys_held[0] = item.key;
            n_held++;
            exp_rsp.found    = 1'b1;
            exp_rsp.position = mtfl_pkg::POS_W'(1);
         end
      end else begin
         // Scan from the back so that the first match from the front wins.
         idx = n_held;
         for (j = n_held - 1; j >= 0; j--) begin
            if (keys_held[j] == item.key) idx = j;
         end
         if (idx < n_held) begin
            exp_rsp.found    = 1'b1;
            exp_rsp.position = mtfl_pkg::POS_W'(idx + 1);
            n_hits++;
            if (item.func == mtfl_pkg::FUNC_MTF) begin
               for (j = idx; j > 0; j--) keys_held[j] = keys_held[j-1];
               keys_held[0] = item.key;
            end else if (item.func == mtfl_pkg::FUNC_DELETE) begin
               for (j = idx; j + 1 < n_held; j++) keys_held[j] = keys_held[j+1];
               n_held--;
            end
         end
      end
      exp_rsp.length = mtfl_pkg::LEN_W'(n_held);
      pending_rsp.push_back(exp_rsp);
   endfunction

   task report(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      n_errors++;
   endtask

   task check_response(mtfl_pkg::rsp_type got);
      mtfl_pkg::rsp_type exp_rsp;
      if (pending_rsp.size() == 0) begin
         report("result item arrived with no input item outstanding");
      end else begin
         exp_rsp = pending_rsp.pop_front();
         n_checked++;
         if (got.found !== exp_rsp.found)
            report($sformatf("found %b, expected %b", got.found, exp_rsp.found));
         if (got.position !== exp_rsp.position)
            report($sformatf("position %0d, expected %0d", got.position, exp_rsp.position));
         if (got.length !== exp_rsp.length)
            report($sformatf("length %0d, expected %0d", got.length, exp_rsp.length));
         if (got.full_error !== exp_rsp.full_error)
            report($sformatf("full_error %b, expected %b",
                             got.full_error, exp_rsp.full_error));
      end
   endtask
endclass

module tb_move_to_front_list_search;

   localparam int DEPTH = 16;
   localparam int RAND_ITEMS = 1850;
   localparam logic [mtfl_pkg::KEY_W-1:0] KEY_MIN = {1'b1, {(mtfl_pkg::KEY_W-1){1'b0}}};
   localparam logic [mtfl_pkg::KEY_W-1:0] KEY_MAX = {1'b0, {(mtfl_pkg::KEY_W-1){1'b1}}};
   localparam logic [mtfl_pkg::KEY_W-1:0] KEY_ONES = '1;

   typedef enum int {PHASE_GROW, PHASE_SHRINK, PHASE_MIX} phase_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   mtfl_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   mtfl_pkg::rsp_type rsp_data;

   // When set, neither side idles.
   bit steady = 1'b0;

   list_order_tracker #(DEPTH) sb;
   int n_sent;
   int n_directed;

   move_to_front_list_search #(
      .DEPTH(DEPTH),
      .KEY_BITS(mtfl_pkg::KEY_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_data);
   end

   // Receiver: runs of ready and stalled cycles, mostly short, now and then long.
   initial begin
      int          pick;
      int unsigned run;
      logic        hold;
      forever begin
         if (steady) begin
            hold = 1'b0;
            run  = 1;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               hold = 1'b0;
               run  = $urandom_range(1, 6);
            end else if (pick < 88) begin
               hold = 1'b1;
               run  = $urandom_range(1, 3);
            end else if (pick < 96) begin
               hold = 1'b0;
               run  = $urandom_range(10, 40);
            end else begin
               hold = 1'b1;
               run  = $urandom_range(6, 25);
            end
         end
         repeat (run) begin
            rsp_stall <= hold;
            @(posedge clock);
         end
      end
   end

   function automatic int unsigned pick_gap();
      int pick;
      if (steady) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 96) return $urandom_range(4, 10);
      return $urandom_range(15, 40);
   endfunction

   // Presents one item, holds it until accepted, then idles for a random gap.
   task automatic send_item(input logic [1:0] op, input logic [mtfl_pkg::KEY_W-1:0] k);
      mtfl_pkg::req_type item;
      int unsigned       gap;
      item.func = op;
      item.key  = k;
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(item);
      n_sent++;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [1:0] pick_op(phase_type kind);
      int pick;
      pick = $urandom_range(0, 99);
      case (kind)
         PHASE_GROW: begin
            if (pick < 55) return mtfl_pkg::FUNC_INSERT;
            if (pick < 70) return mtfl_pkg::FUNC_SEARCH;
            if (pick < 85) return mtfl_pkg::FUNC_MTF;
            return mtfl_pkg::FUNC_DELETE;
         end
         PHASE_SHRINK: begin
            if (pick < 15) return mtfl_pkg::FUNC_INSERT;
            if (pick < 30) return mtfl_pkg::FUNC_SEARCH;
            if (pick < 50) return mtfl_pkg::FUNC_MTF;
            return mtfl_pkg::FUNC_DELETE;
         end
         default: begin
            if (pick < 30) return mtfl_pkg::FUNC_INSERT;
            if (pick < 55) return mtfl_pkg::FUNC_SEARCH;
            if (pick < 80) return mtfl_pkg::FUNC_MTF;
            return mtfl_pkg::FUNC_DELETE;
         end
      endcase
   endfunction

   initial begin
      #8_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      logic [mtfl_pkg::KEY_W-1:0] key_pool[8];
      logic [mtfl_pkg::KEY_W-1:0] k;
      logic [1:0]                 op;
      phase_type                  kind;
      int                         n_rand;
      int                         phase_len;
      int                         pick;
      int                         spins;
      int                         i;

      sb         = new();
      n_sent     = 0;
      n_rand     = 0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Lookups on an empty list must all miss.
      send_item(mtfl_pkg::FUNC_SEARCH, '0);
      send_item(mtfl_pkg::FUNC_MTF, KEY_MIN);
      send_item(mtfl_pkg::FUNC_DELETE, KEY_MAX);
      // Extreme keys, with a duplicate at the front.
      send_item(mtfl_pkg::FUNC_INSERT, KEY_MIN);
      send_item(mtfl_pkg::FUNC_INSERT, KEY_MAX);
      send_item(mtfl_pkg::FUNC_INSERT, '0);
      send_item(mtfl_pkg::FUNC_INSERT, KEY_ONES);
      send_item(mtfl_pkg::FUNC_INSERT, KEY_ONES);
      send_item(mtfl_pkg::FUNC_SEARCH, KEY_MAX);
      send_item(mtfl_pkg::FUNC_MTF, KEY_ONES);       // match already at the front
      send_item(mtfl_pkg::FUNC_MTF, KEY_MIN);        // match at the back
      send_item(mtfl_pkg::FUNC_DELETE, KEY_ONES);    // only the first duplicate goes
      send_item(mtfl_pkg::FUNC_SEARCH, mtfl_pkg::KEY_W'(1));
      send_item(mtfl_pkg::FUNC_DELETE, mtfl_pkg::KEY_W'(1));
      while (sb.n_held < DEPTH) send_item(mtfl_pkg::FUNC_INSERT, $urandom);
      send_item(mtfl_pkg::FUNC_INSERT, mtfl_pkg::KEY_W'(5));   // refused, list is full
      send_item(mtfl_pkg::FUNC_SEARCH, KEY_MAX);     // last slot
      send_item(mtfl_pkg::FUNC_DELETE, KEY_MAX);
      n_directed = n_sent;

      while (n_rand < RAND_ITEMS) begin
         steady    = ($urandom_range(0, 4) == 0);
         kind      = phase_type'($urandom_range(0, 2));
         phase_len = $urandom_range(20, 80);
         for (i = 0; i < 8; i++) begin
            key_pool[i] = $urandom;
            if ($urandom_range(0, 7) == 0) begin
               case ($urandom_range(0, 3))
                  0:       key_pool[i] = KEY_MIN;
                  1:       key_pool[i] = KEY_MAX;
                  2:       key_pool[i] = '0;
                  default: key_pool[i] = KEY_ONES;
               endcase
            end
         end
         repeat (phase_len) begin
            op   = pick_op(kind);
            pick = $urandom_range(0, 99);
            if (pick < 15)
               k = $urandom;
            else if (pick < 45 && sb.n_held > 0)
               k = sb.keys_held[$urandom_range(0, sb.n_held - 1)];
            else
               k = key_pool[$urandom_range(0, 7)];
            send_item(op, k);
            n_rand++;
         end
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      spins = 0;
      while (sb.pending_rsp.size() != 0 && spins < 5000) begin
         @(posedge clock);
         spins++;
      end
      repeat (8) @(posedge clock);
      if (sb.pending_rsp.size() != 0)
         sb.report($sformatf("%0d result items never arrived", sb.pending_rsp.size()));

      $display("Sent %0d items (%0d directed) over grow, shrink and mixed phases.",
               n_sent, n_directed);
      $display("Checked %0d result items: %0d key matches, %0d inserts refused on a full list.",
               sb.n_checked, sb.n_hits, sb.n_refused);
      if (sb.n_errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
